[rtl/telrx_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telrx_pkg: shared codes for the telnet receive filter
// Telnet command codes, parser state codes, input kinds, result destinations
// and counts of beats left in the output register.
package telrx_pkg;

    // Telnet command bytes
    localparam logic [7:0] IAC  = 8'hFF;
    localparam logic [7:0] SE   = 8'hF0;
    localparam logic [7:0] SB   = 8'hFA;
    localparam logic [7:0] WILL = 8'hFB;
    localparam logic [7:0] WONT = 8'hFC;
    localparam logic [7:0] DO   = 8'hFD;
    localparam logic [7:0] DONT = 8'hFE;

    // Parser state
    typedef logic [2:0] t_parse_state;

    localparam t_parse_state ST_DATA  = 3'd0;
    localparam t_parse_state ST_IAC   = 3'd1;
    localparam t_parse_state ST_WILL  = 3'd2;
    localparam t_parse_state ST_WONT  = 3'd3;
    localparam t_parse_state ST_DO    = 3'd4;
    localparam t_parse_state ST_DONT  = 3'd5;
    localparam t_parse_state ST_SB    = 3'd6;
    localparam t_parse_state ST_SBIAC = 3'd7;

    // Input kinds
    localparam logic KIND_BYTE    = 1'b0;
    localparam logic KIND_CONNECT = 1'b1;

    // Result destinations
    localparam logic DEST_CPU = 1'b0;
    localparam logic DEST_NET = 1'b1;

    // Beats left in the output register
    typedef logic [1:0] t_beat_cnt;

    localparam t_beat_cnt BEATS_NONE  = 2'd0;
    localparam t_beat_cnt BEATS_ONE   = 2'd1;
    localparam t_beat_cnt BEATS_TWO   = 2'd2;
    localparam t_beat_cnt BEATS_REPLY = 2'd3;

endpackage

[rtl/telnet_receive_filter.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telnet_receive_filter: telnet receive parser with option refusal
// Passes data bytes to the CPU side, unescapes IAC IAC, refuses all options
// and drops commands and subnegotiations.
// ---------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_ready): one beat per received byte or
//   connect event (i_kind = 1). i_chunk_end is carried but does not change
//   the filtering; sequences may span chunks.
//   Output channel (o_out_valid / i_out_ready): each beat is one byte with
//   o_dest (0 = CPU, 1 = network reply) and o_last on the final beat that
//   an input caused. An input gives no beat, one CPU beat, or a reply burst
//   of three network beats (IAC, DONT/WONT, option).
//   Latency: results appear the cycle after the input beat is accepted.
//   Throughput: one input per cycle while each input gives at most one
//   beat and the receiver is ready; a reply burst holds the output
//   register until its three beats leave, which sets the reply rate.
//   The input is taken while the last pending beat leaves, so a stalled
//   receiver holds o_in_ready low only once the output register is busy.
//   Reset puts the parser in the data state and empties the output register.
// ---------------------------------------------------------------------------
module telnet_receive_filter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic       i_chunk_end,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_dest,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    telrx_pkg::t_parse_state r_state, n_state;
    telrx_pkg::t_beat_cnt    r_beats, n_beats;
    logic                    r_dest,  n_dest;
    logic [7:0]              r_byte,  n_byte;  // CPU byte or reply option
    logic [7:0]              r_verb,  n_verb;  // reply verb

    logic in_fire;
    logic out_fire;
    logic in_byte;

    assign out_fire   = o_out_valid && i_out_ready;
    assign o_in_ready = (r_beats == telrx_pkg::BEATS_NONE) ||
                        ((r_beats == telrx_pkg::BEATS_ONE) && i_out_ready);
    assign in_fire    = i_in_valid && o_in_ready;
    // chunk marks only qualify data bytes; they never change the parse
    assign in_byte    = (i_kind == telrx_pkg::KIND_BYTE) && (i_chunk_end || !i_chunk_end);

    // Parser step and result load
    always_comb begin
        n_state = r_state;
        n_beats = r_beats;
        n_dest  = r_dest;
        n_byte  = r_byte;
        n_verb  = r_verb;
        if (out_fire) begin
            n_beats = r_beats - telrx_pkg::BEATS_ONE;
        end
        if (in_fire) begin
            if (!in_byte) begin
                n_state = telrx_pkg::ST_DATA;
            end else begin
                unique case (r_state)
                    telrx_pkg::ST_DATA: begin
                        if (i_rx_byte == telrx_pkg::IAC) begin
                            n_state = telrx_pkg::ST_IAC;
                        end else begin
                            n_beats = telrx_pkg::BEATS_ONE;
                            n_dest  = telrx_pkg::DEST_CPU;
                            n_byte  = i_rx_byte;
                        end
                    end
                    telrx_pkg::ST_IAC: begin
                        priority case (i_rx_byte)
                            telrx_pkg::IAC: begin
                                n_state = telrx_pkg::ST_DATA;
                                n_beats = telrx_pkg::BEATS_ONE;
                                n_dest  = telrx_pkg::DEST_CPU;
                                n_byte  = telrx_pkg::IAC;
                            end
                            telrx_pkg::WILL: n_state = telrx_pkg::ST_WILL;
                            telrx_pkg::WONT: n_state = telrx_pkg::ST_WONT;
                            telrx_pkg::DO:   n_state = telrx_pkg::ST_DO;
                            telrx_pkg::DONT: n_state = telrx_pkg::ST_DONT;
                            telrx_pkg::SB:   n_state = telrx_pkg::ST_SB;
                            default:         n_state = telrx_pkg::ST_DATA;
                        endcase
                    end
                    telrx_pkg::ST_WILL: begin
                        n_state = telrx_pkg::ST_DATA;
                        n_beats = telrx_pkg::BEATS_REPLY;
                        n_dest  = telrx_pkg::DEST_NET;
                        n_verb  = telrx_pkg::DONT;
                        n_byte  = i_rx_byte;
                    end
                    telrx_pkg::ST_DO: begin
                        n_state = telrx_pkg::ST_DATA;
                        n_beats = telrx_pkg::BEATS_REPLY;
                        n_dest  = telrx_pkg::DEST_NET;
                        n_verb  = telrx_pkg::WONT;
                        n_byte  = i_rx_byte;
                    end
                    telrx_pkg::ST_WONT, telrx_pkg::ST_DONT: begin
                        n_state = telrx_pkg::ST_DATA;
                    end
                    telrx_pkg::ST_SB: begin
                        if (i_rx_byte == telrx_pkg::IAC) begin
                            n_state = telrx_pkg::ST_SBIAC;
                        end
                    end
                    telrx_pkg::ST_SBIAC: begin
                        n_state = (i_rx_byte == telrx_pkg::SE) ? telrx_pkg::ST_DATA
                                                                : telrx_pkg::ST_SB;
                    end
                    default: n_state = telrx_pkg::ST_DATA;
                endcase
            end
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= telrx_pkg::ST_DATA;
            r_beats <= telrx_pkg::BEATS_NONE;
        end else begin
            r_state <= n_state;
            r_beats <= n_beats;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_dest <= n_dest;
        r_byte <= n_byte;
        r_verb <= n_verb;
    end

    // Output beat select: reply bursts go IAC, verb, option
    always_comb begin
        o_out_valid = (r_beats != telrx_pkg::BEATS_NONE);
        o_dest      = r_dest;
        o_last      = (r_beats == telrx_pkg::BEATS_ONE);
        unique case (r_beats)
            telrx_pkg::BEATS_REPLY: o_out_byte = telrx_pkg::IAC;
            telrx_pkg::BEATS_TWO:   o_out_byte = r_verb;
            default:                o_out_byte = r_byte;
        endcase
    end

    // Checks
    a_connect_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && (i_kind == telrx_pkg::KIND_CONNECT) |=> r_state == telrx_pkg::ST_DATA)
        else $error("connect event did not return parser to data state");

    a_cpu_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_dest == telrx_pkg::DEST_CPU) |-> o_last)
        else $error("CPU beat not marked last");

    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire && !o_last |=> o_out_valid && (o_dest == telrx_pkg::DEST_NET))
        else $error("reply burst broken");

    a_reply_opens_iac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && in_byte && ((r_state == telrx_pkg::ST_WILL) ||
        (r_state == telrx_pkg::ST_DO)) |=> o_out_valid && (o_out_byte == telrx_pkg::IAC))
        else $error("reply burst does not open with IAC");

endmodule

[bench/telnet_receive_filter_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// telnet_receive_filter_tb: self-checking bench for the telnet receive filter
// Drives byte and connect beats through the input channel, predicts the CPU
// bytes and refusal replies in a small parser model, and compares every
// output beat in order. Runs directed sequences first, then random telnet
// traffic under several sender idle / receiver stall mixes.
// ---------------------------------------------------------------------------
module telnet_receive_filter_tb;

    localparam int CLK_HALF_NS  = 4;
    localparam int LIMIT_NS     = 3_000_000;
    localparam int PHASE_BEATS  = 50;
    localparam int HOLD_CYCLES  = 80;
    localparam int TAIL_CYCLES  = 8;

    // one output beat as seen on the result channel
    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
    } t_out_beat;

    // Parser model: tracks telnet state and queues the beats each input causes
    class telrx_filter_model;
        telrx_pkg::t_parse_state state;
        t_out_beat               pending_beats[$];
        int                      n_errors;
        int                      n_checked;
        int                      n_cpu;
        int                      n_refusals;
        int                      n_connects;

        function new();
            state      = telrx_pkg::ST_DATA;
            n_errors   = 0;
            n_checked  = 0;
            n_cpu      = 0;
            n_refusals = 0;
            n_connects = 0;
        endfunction

        // append one expected beat at the tail
        function void queue_beat(t_out_beat b);
            pending_beats.insert(pending_beats.size(), b);
        endfunction

        function void push_cpu(logic [7:0] data);
            t_out_beat b;
            b.dest = telrx_pkg::DEST_CPU;
            b.data = data;
            b.last = 1'b1;
            queue_beat(b);
            n_cpu++;
        endfunction

        // IAC, refusing verb, option, all toward the network
        function void push_refusal(logic [7:0] verb, logic [7:0] opt);
            t_out_beat b;
            b.dest = telrx_pkg::DEST_NET;
            b.last = 1'b0;
            b.data = telrx_pkg::IAC;
            queue_beat(b);
            b.data = verb;
            queue_beat(b);
            b.data = opt;
            b.last = 1'b1;
            queue_beat(b);
            n_refusals++;
        endfunction

        // note one accepted input beat
        function void take_rx(logic kind, logic [7:0] rx);
            if (kind == telrx_pkg::KIND_CONNECT) begin
                state = telrx_pkg::ST_DATA;
                n_connects++;
                return;
            end
            case (state)
                telrx_pkg::ST_DATA: begin
                    if (rx == telrx_pkg::IAC) state = telrx_pkg::ST_IAC;
                    else                      push_cpu(rx);
                end
                telrx_pkg::ST_IAC: begin
                    case (rx)
                        telrx_pkg::IAC: begin
                            state = telrx_pkg::ST_DATA;
                            push_cpu(telrx_pkg::IAC);
                        end
                        telrx_pkg::WILL: state = telrx_pkg::ST_WILL;
                        telrx_pkg::WONT: state = telrx_pkg::ST_WONT;
                        telrx_pkg::DO:   state = telrx_pkg::ST_DO;
                        telrx_pkg::DONT: state = telrx_pkg::ST_DONT;
                        telrx_pkg::SB:   state = telrx_pkg::ST_SB;
                        default:         state = telrx_pkg::ST_DATA;
                    endcase
                end
                telrx_pkg::ST_WILL: begin
                    state = telrx_pkg::ST_DATA;
                    push_refusal(telrx_pkg::DONT, rx);
                end
                telrx_pkg::ST_DO: begin
                    state = telrx_pkg::ST_DATA;
                    push_refusal(telrx_pkg::WONT, rx);
                end
                telrx_pkg::ST_WONT, telrx_pkg::ST_DONT: state = telrx_pkg::ST_DATA;
                telrx_pkg::ST_SB: begin
                    if (rx == telrx_pkg::IAC) state = telrx_pkg::ST_SBIAC;
                end
                default: state = (rx == telrx_pkg::SE) ? telrx_pkg::ST_DATA
                                                       : telrx_pkg::ST_SB;
            endcase
        endfunction

        // compare one accepted output beat against the oldest expectation
        function void check_out_beat(logic dest, logic [7:0] data, logic last);
            t_out_beat exp_b;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat dest=%0d byte=%h last=%0d",
                         $realtime, dest, data, last);
                n_errors++;
                return;
            end
            exp_b = pending_beats.pop_front();
            n_checked++;
            if (dest !== exp_b.dest) begin
                $display("%0t: dest mismatch, expected %0d actual %0d",
                         $realtime, exp_b.dest, dest);
                n_errors++;
            end
            if (data !== exp_b.data) begin
                $display("%0t: byte mismatch, expected %h actual %h",
                         $realtime, exp_b.data, data);
                n_errors++;
            end
            if (last !== exp_b.last) begin
                $display("%0t: last mismatch, expected %0d actual %0d",
                         $realtime, exp_b.last, last);
                n_errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic       i_kind;
    logic [7:0] i_rx_byte;
    logic       i_chunk_end;
    logic       o_out_valid;
    logic       i_out_ready;
    logic       o_dest;
    logic [7:0] o_out_byte;
    logic       o_last;

    telrx_filter_model filter = new();

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int hold_left    = 0;
    int rx_beats     = 0;

    telnet_receive_filter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_rx_byte   (i_rx_byte),
        .i_chunk_end (i_chunk_end),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_dest      (o_dest),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(LIMIT_NS);
        $display("timeout at %0t, %0d beats still expected",
                 $realtime, filter.pending_beats.size());
        $display("telnet_receive_filter_tb NOT OK");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            filter.check_out_beat(o_dest, o_out_byte, o_last);
    end

    // offer one input beat after a random gap; returns at the next falling edge
    task automatic send_beat(input logic kind, input logic [7:0] rx);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_rx_byte   <= rx;
        i_chunk_end <= ($urandom_range(3) == 0);
        do @(posedge i_clk); while (!o_in_ready);
        filter.take_rx(kind, rx);
        rx_beats++;
        @(negedge i_clk);
    endtask

    task automatic send_data(input logic [7:0] rx);
        send_beat(telrx_pkg::KIND_BYTE, rx);
    endtask

    // stop offering and wait for every expected beat, then a short tail
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (filter.pending_beats.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // one random telnet sequence, mostly well formed
    task automatic send_random_sequence();
        int pick;
        int body_len;
        pick = $urandom_range(99);
        if (pick < 30) begin
            send_data(8'($urandom_range(254)));
        end else if (pick < 40) begin
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::IAC);
        end else if (pick < 55) begin
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::WILL);
            send_data(8'($urandom_range(255)));
        end else if (pick < 70) begin
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::DO);
            send_data(8'($urandom_range(255)));
        end else if (pick < 76) begin
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::WONT);
            send_data(8'($urandom_range(255)));
        end else if (pick < 82) begin
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::DONT);
            send_data(8'($urandom_range(255)));
        end else if (pick < 86) begin
            // any command byte after IAC
            send_data(telrx_pkg::IAC);
            send_data(8'($urandom_range(255)));
        end else if (pick < 93) begin
            // subnegotiation with random body
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::SB);
            body_len = $urandom_range(6);
            repeat (body_len) begin
                if ($urandom_range(4) == 0) begin
                    send_data(telrx_pkg::IAC);
                    send_data(8'($urandom_range(8'hEF)));
                end else begin
                    send_data(8'($urandom_range(255)));
                end
            end
            send_data(telrx_pkg::IAC);
            send_data(telrx_pkg::SE);
        end else if (pick < 97) begin
            send_beat(telrx_pkg::KIND_CONNECT, 8'($urandom_range(255)));
        end else begin
            // noise
            send_beat(1'($urandom_range(1)), 8'($urandom_range(255)));
        end
    endtask

    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int target;
        tx_idle_pct  = idle_pct;
        rx_stall_pct = stall_pct;
        target       = rx_beats + PHASE_BEATS;
        while (rx_beats < target) send_random_sequence();
        wait_drained();
    endtask

    // main sequence
    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_kind      = telrx_pkg::KIND_BYTE;
        i_rx_byte   = 8'h00;
        i_chunk_end = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: data extremes, escaped IAC, each verb, commands, SB
        send_data(8'h00);
        send_data(telrx_pkg::DONT);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::WILL);
        send_data(8'h00);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::DO);
        send_data(8'hFF);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::WONT);
        send_data(8'h01);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::DONT);
        send_data(8'h18);
        // unknown command is dropped
        send_data(telrx_pkg::IAC);
        send_data(8'hF1);
        // IAC then non-SE stays inside the subnegotiation
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::SB);
        send_data(telrx_pkg::IAC);
        send_data(8'h01);
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::SE);
        // connect event in the middle of a sequence
        send_data(telrx_pkg::IAC);
        send_data(telrx_pkg::WILL);
        send_beat(telrx_pkg::KIND_CONNECT, 8'hFF);
        send_data(8'h7F);
        wait_drained();

        run_random_phase(0, 0);

        // long receiver hold-off with the sender pushing back to back
        hold_left = HOLD_CYCLES;
        run_random_phase(0, 0);

        run_random_phase(85, 0);
        run_random_phase(0, 85);
        run_random_phase(22, 22);

        if (filter.pending_beats.size() != 0) begin
            $display("%0t: %0d expected beats never arrived",
                     $realtime, filter.pending_beats.size());
            filter.n_errors++;
        end
        $display("%0d input beats (%0d connect events), %0d output beats checked",
                 rx_beats, filter.n_connects, filter.n_checked);
        $display("%0d CPU bytes and %0d option refusals predicted, %0d errors",
                 filter.n_cpu, filter.n_refusals, filter.n_errors);
        if (filter.n_errors == 0) begin
            $display("telnet_receive_filter_tb OK");
        end else begin
            $display("telnet_receive_filter_tb NOT OK");
        end
        $finish;
    end

endmodule
